// ===== hdl/dmmn_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmmn_pkg
// Shared types for the depth min/max normalizer: channel payloads, the
// controller state encoding and the controller/datapath command and status bundles.
// ---------------------------------------------------------------------------
package dmmn_pkg;

   localparam int SampleWidth = 16;
   localparam int PixelWidth  = 8;
   localparam int StepCount   = PixelWidth;

   localparam logic ActionMeasure   = 1'b0;
   localparam logic ActionNormalize = 1'b1;

   typedef struct packed {
      logic                          action;
      logic signed [SampleWidth-1:0] sample;
      logic                          frame_start;
      logic                          frame_end;
   } dmmn_req_type;

   typedef struct packed {
      logic [PixelWidth-1:0] pixel;
      logic                  end_of_frame;
   } dmmn_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_EMIT
   } dmmn_state_type;

   typedef struct packed {
      logic load;     // capture the request
      logic measure;  // fold the request sample into min/max
      logic prep;     // compute range, offset and divider operands
      logic step;     // one restoring divide step
      logic emit;     // move the quotient into the output register
   } dmmn_cmd_type;

   typedef struct packed {
      logic early;     // result known without dividing
      logic last_step; // final divide step this cycle
      logic out_free;  // output register can take a result
   } dmmn_status_type;

endpackage

// ===== hdl/depth_min_max_normalizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_min_max_normalizer
// Two-pass depth frame normalizer: a measure pass tracks min/max, a
// normalize pass maps each Q8.8 sample to an 8-bit pixel.
//
//   channel  ports                                 direction
//   req      req_valid / req_ready / req_payload   in   sample requests
//   rsp      rsp_valid / rsp_ready / rsp_payload   out  pixels
//   csr      csr_valid / csr_ready / csr_wdata     in   flat threshold
//
// A measure request is taken in idle. A normalize request runs accept,
// prepare, 8 restoring divide steps and hand-off, or skips the divide when
// the pixel is flat or clamped. The 8-step divider sets the rate.
// Synchronous reset clears min, max and the threshold to zero.
// A stalled rsp holds the block in hand-off; csr is always ready.
// ---------------------------------------------------------------------------
module depth_min_max_normalizer
   import dmmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dmmn_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dmmn_rsp_type           rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SampleWidth-1:0] csr_wdata
);

   dmmn_cmd_type    cmd;
   dmmn_status_type status;

   assign csr_ready = 1'b1;

   dmmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   dmmn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/dmmn_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmmn_ctrl
// Sequencer: accepts a request; for a normalize request runs prepare, eight
// divide steps unless the result is known early, and the hand-off.
// ---------------------------------------------------------------------------
module dmmn_ctrl
   import dmmn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_action,
   output logic            req_ready,
   input  dmmn_status_type status,
   output dmmn_cmd_type    cmd
);

   dmmn_state_type state_ff;
   dmmn_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_action == ActionMeasure) begin
                  cmd.measure = 1'b1;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.early ? ST_EMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/dmmn_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmmn_datapath
// Min/max tracking, threshold register, restoring divider for
// (sample - min) * 255 / range and the output register.
// ---------------------------------------------------------------------------
module dmmn_datapath
   import dmmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dmmn_cmd_type           cmd,
   output dmmn_status_type        status,
   input  dmmn_req_type           req_payload,
   input  logic                   csr_valid,
   input  logic [SampleWidth-1:0] csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dmmn_rsp_type           rsp_payload
);

   localparam int CntWidth = $clog2(StepCount);

   logic [SampleWidth-1:0]        thresh_ff;
   logic signed [SampleWidth-1:0] min_ff;
   logic signed [SampleWidth-1:0] max_ff;
   logic signed [SampleWidth-1:0] sample_ff;
   logic                          fend_ff;
   logic [SampleWidth-1:0]        range_ff;
   logic [SampleWidth-1:0]        rem_ff;
   logic [PixelWidth-1:0]         num_lo_ff;
   logic [PixelWidth-1:0]         quot_ff;
   logic [CntWidth-1:0]           cnt_ff;
   logic                          rsp_valid_ff;
   dmmn_rsp_type                  rsp_ff;

   logic signed [SampleWidth:0]           range_s;
   logic signed [SampleWidth:0]           diff_s;
   logic                                  flat;
   logic                                  nonpos;
   logic                                  clamp_hi;
   logic [SampleWidth+PixelWidth-1:0]     num;
   logic [SampleWidth:0]                  trial;
   logic                                  trial_ge;

   // operands for the prepare cycle
   assign range_s  = {max_ff[SampleWidth-1], max_ff} - {min_ff[SampleWidth-1], min_ff};
   assign diff_s   = {sample_ff[SampleWidth-1], sample_ff} - {min_ff[SampleWidth-1], min_ff};
   assign flat     = range_s[SampleWidth] || (range_s[SampleWidth-1:0] <= thresh_ff);
   assign nonpos   = diff_s[SampleWidth] || (diff_s == '0);
   assign clamp_hi = !diff_s[SampleWidth]
                     && (diff_s[SampleWidth-1:0] >= range_s[SampleWidth-1:0]);
   // diff * 255 as a shift and subtract; only used when diff < range
   assign num      = {diff_s[SampleWidth-1:0], {PixelWidth{1'b0}}}
                     - {{PixelWidth{1'b0}}, diff_s[SampleWidth-1:0]};

   assign trial    = {rem_ff, num_lo_ff[PixelWidth-1]};
   assign trial_ge = trial >= {1'b0, range_ff};

   assign status.early     = flat || nonpos || clamp_hi;
   assign status.last_step = (cnt_ff == CntWidth'(StepCount - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_wdata;
         end
         if (cmd.measure) begin
            if (req_payload.frame_start) begin
               min_ff <= req_payload.sample;
               max_ff <= req_payload.sample;
            end else begin
               if (req_payload.sample < min_ff) begin
                  min_ff <= req_payload.sample;
               end
               if (req_payload.sample > max_ff) begin
                  max_ff <= req_payload.sample;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_payload.sample;
         fend_ff   <= req_payload.frame_end;
      end
      if (cmd.prep) begin
         range_ff  <= range_s[SampleWidth-1:0];
         rem_ff    <= num[SampleWidth+PixelWidth-1:PixelWidth];
         num_lo_ff <= num[PixelWidth-1:0];
         cnt_ff    <= '0;
         quot_ff   <= (clamp_hi && !flat && !nonpos) ? {PixelWidth{1'b1}} : '0;
      end else if (cmd.step) begin
         rem_ff    <= trial_ge ? SampleWidth'(trial - {1'b0, range_ff})
                               : trial[SampleWidth-1:0];
         num_lo_ff <= {num_lo_ff[PixelWidth-2:0], 1'b0};
         quot_ff   <= {quot_ff[PixelWidth-2:0], trial_ge};
         cnt_ff    <= cnt_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_ff.pixel        <= quot_ff;
         rsp_ff.end_of_frame <= fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/sv/tb_depth_min_max_normalizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_depth_min_max_normalizer
// Self-checking bench for the two-pass depth normalizer. A directed table
// covers the field extremes, clamping, flat frames and the reset state.
// Random frames follow: measure pass, then normalize pass, mixed with noise.
// Every pixel is checked in order, against a fixed value or a predictor of min/max stretching.
// ---------------------------------------------------------------------------
module tb_depth_min_max_normalizer;
   import dmmn_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 16;
   localparam int HoldCycles  = 400;
   localparam int IdlePercent = 22;
   localparam int PhaseCount  = 6;
   localparam int PhaseBudget = 95;
   localparam int RowCount    = 22;
   localparam int FrameRowFirst = 12;
   localparam int FrameRowLast  = 19;

   typedef struct packed {
      dmmn_req_type item;
      logic         typed;
      logic [7:0]   pixel;
   } stim_row_type;

   // Fixed expectations only where the answer is obvious; the rest go to
   // the predictor.
   localparam stim_row_type DirectedRows [RowCount] = '{
      '{'{ActionNormalize, 16'sh1234, 1'b0, 1'b0}, 1'b1, 8'd0},   // flat from reset
      '{'{ActionNormalize, 16'sh8000, 1'b0, 1'b1}, 1'b1, 8'd0},
      '{'{ActionMeasure,   16'sh0007, 1'b0, 1'b0}, 1'b0, 8'd0},   // fold into reset min/max
      '{'{ActionNormalize, 16'sh0007, 1'b0, 1'b1}, 1'b1, 8'd255},
      '{'{ActionMeasure,   16'sh8000, 1'b1, 1'b0}, 1'b0, 8'd0},   // reload at frame start
      '{'{ActionMeasure,   16'sh7fff, 1'b0, 1'b0}, 1'b0, 8'd0},
      '{'{ActionMeasure,   16'sh0000, 1'b0, 1'b1}, 1'b0, 8'd0},   // frame end, no pixel
      '{'{ActionNormalize, 16'sh8000, 1'b0, 1'b0}, 1'b1, 8'd0},
      '{'{ActionNormalize, 16'sh7fff, 1'b0, 1'b0}, 1'b1, 8'd255},
      '{'{ActionNormalize, 16'sh0000, 1'b0, 1'b0}, 1'b0, 8'd0},
      '{'{ActionNormalize, 16'sh0001, 1'b1, 1'b0}, 1'b0, 8'd0},   // frame start ignored
      '{'{ActionNormalize, 16'shffff, 1'b0, 1'b1}, 1'b0, 8'd0},
      '{'{ActionMeasure,   16'sd100,  1'b1, 1'b0}, 1'b0, 8'd0},
      '{'{ActionMeasure,   16'sd200,  1'b0, 1'b0}, 1'b0, 8'd0},
      '{'{ActionMeasure,   16'sd150,  1'b0, 1'b1}, 1'b0, 8'd0},
      '{'{ActionNormalize, 16'sd50,   1'b0, 1'b0}, 1'b1, 8'd0},   // below min
      '{'{ActionNormalize, 16'sd300,  1'b0, 1'b0}, 1'b1, 8'd255}, // above max
      '{'{ActionNormalize, 16'sd100,  1'b0, 1'b0}, 1'b1, 8'd0},
      '{'{ActionNormalize, 16'sd200,  1'b0, 1'b0}, 1'b1, 8'd255},
      '{'{ActionNormalize, 16'sd133,  1'b0, 1'b1}, 1'b0, 8'd0},
      '{'{ActionMeasure,   16'sd500,  1'b1, 1'b1}, 1'b0, 8'd0},   // zero range
      '{'{ActionNormalize, 16'sd600,  1'b0, 1'b1}, 1'b1, 8'd0}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   dmmn_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   dmmn_rsp_type rsp_payload;
   logic         csr_valid;
   logic         csr_ready;
   logic [SampleWidth-1:0] csr_wdata;

   // predictor state
   logic signed [SampleWidth-1:0] track_min;
   logic signed [SampleWidth-1:0] track_max;
   logic [SampleWidth-1:0]        flat_level;
   dmmn_rsp_type                  pixel_queue [$];

   int  mismatches;
   int  requests_sent;
   int  pixels_checked;
   int  cycle_count;
   int  levels_written;
   bit  steady_phase;
   bit  hold_done;

   depth_min_max_normalizer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
                  pixel_queue.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endtask

   function automatic logic [PixelWidth-1:0] predict_pixel(
      input logic signed [SampleWidth-1:0] sample
   );
      int span;
      int offset;
      int quotient;
      span = int'(track_max) - int'(track_min);
      if (span <= int'(flat_level) || span <= 0) begin
         return '0;
      end
      offset = int'(sample) - int'(track_min);
      if (offset <= 0) begin
         return '0;
      end
      quotient = (offset * 255) / span;
      if (quotient > 255) begin
         quotient = 255;
      end
      return quotient[PixelWidth-1:0];
   endfunction

   // Called at a rising edge; returns at the edge that accepts the request,
   // with req_valid still high so the next request can follow back to back.
   task automatic send_request(input dmmn_req_type item, input bit typed,
                               input logic [PixelWidth-1:0] typed_pixel);
      int gap;
      gap = 0;
      if (!steady_phase) begin
         while ($urandom_range(99) < IdlePercent) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (item.action == ActionNormalize) begin
         pixel_queue.push_back('{
            pixel:        typed ? typed_pixel : predict_pixel(item.sample),
            end_of_frame: item.frame_end
         });
      end else if (item.frame_start) begin
         track_min = item.sample;
         track_max = item.sample;
      end else begin
         if (item.sample < track_min) track_min = item.sample;
         if (item.sample > track_max) track_max = item.sample;
      end
   endtask

   // Drain the block, then write the flat threshold.
   task automatic write_threshold(input logic [SampleWidth-1:0] level);
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= level;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      flat_level = level;
      levels_written++;
   endtask

   task automatic run_frames(input int budget);
      logic signed [SampleWidth-1:0] frame_samples [$];
      logic [SampleWidth-1:0]        spread;
      logic [SampleWidth-1:0]        floor_raw;
      logic [SampleWidth-1:0]        raw;
      logic [31:0]                   noise_word;
      logic [$bits(dmmn_req_type)-1:0] noise_bits;
      dmmn_req_type                  item;
      int  sent;
      int  len;
      bit  skip_start;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 12) begin
            noise_word = $urandom;
            noise_bits = noise_word[$bits(dmmn_req_type)-1:0];
            send_request(noise_bits, 1'b0, '0);
            sent++;
         end else begin
            len        = $urandom_range(1, 10);
            spread     = 16'((32'd1 << $urandom_range(0, 16)) - 1);
            floor_raw  = 16'($urandom_range(0, 65535 - int'(spread)));
            skip_start = ($urandom_range(99) < 10);
            frame_samples.delete();
            for (int i = 0; i < len; i++) begin
               // offset binary to two's complement
               raw = floor_raw + 16'($urandom_range(0, int'(spread)));
               frame_samples.push_back(raw ^ 16'h8000);
            end
            for (int i = 0; i < len; i++) begin
               item.action      = ActionMeasure;
               item.sample      = frame_samples[i];
               item.frame_start = (i == 0) && !skip_start;
               item.frame_end   = (i == len - 1);
               send_request(item, 1'b0, '0);
            end
            sent += len;
            // occasionally drop the normalize pass
            if ($urandom_range(99) >= 8) begin
               for (int i = 0; i < len; i++) begin
                  item.action      = ActionNormalize;
                  item.sample      = ($urandom_range(99) < 15) ? 16'($urandom)
                                                               : frame_samples[i];
                  item.frame_start = ($urandom_range(99) < 10);
                  item.frame_end   = (i == len - 1);
                  send_request(item, 1'b0, '0);
               end
               sent += len;
            end
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off to back up the block.
   initial begin : rsp_side
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && pixels_checked >= 150) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (steady_phase) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      dmmn_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         pixels_checked++;
         if (pixel_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %0d", rsp_payload.pixel));
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_payload.pixel !== want.pixel) begin
               report_mismatch($sformatf("pixel %0d, want %0d",
                                         rsp_payload.pixel, want.pixel));
            end
            if (rsp_payload.end_of_frame !== want.end_of_frame) begin
               report_mismatch($sformatf("end_of_frame %0b, want %0b",
                                         rsp_payload.end_of_frame, want.end_of_frame));
            end
         end
      end
   end

   initial begin : stimulus
      logic [SampleWidth-1:0] phase_level [PhaseCount];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      track_min   = '0;
      track_max   = '0;
      flat_level  = '0;
      phase_level[0] = 16'hffff;
      phase_level[1] = 16'h0000;
      phase_level[2] = 16'($urandom_range(0, 255));
      phase_level[3] = 16'($urandom);
      phase_level[4] = 16'($urandom_range(0, 4095));
      phase_level[5] = 16'h0000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < RowCount; r++) begin
         send_request(DirectedRows[r].item, DirectedRows[r].typed, DirectedRows[r].pixel);
      end
      // range equal to the threshold: the same frame goes flat
      write_threshold(16'd100);
      for (int r = FrameRowFirst; r <= FrameRowLast; r++) begin
         send_request(DirectedRows[r].item, 1'b0, '0);
      end

      for (int p = 0; p < PhaseCount; p++) begin
         write_threshold(phase_level[p]);
         steady_phase = (p == 2);
         run_frames(PhaseBudget);
      end
      steady_phase = 1'b0;
      req_valid <= 1'b0;

      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d requests, %0d pixels checked, %0d threshold writes",
               requests_sent, pixels_checked, levels_written);
      $display("directed extremes and flat frames, random frames with noise, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/dmmn_pkg.sv
hdl/dmmn_ctrl.sv
hdl/dmmn_datapath.sv
hdl/depth_min_max_normalizer.sv
tb/sv/tb_depth_min_max_normalizer.sv
